// File: hdl/pfsa_pkg.sv
// Shared types and constants for the page frame state allocator.
package pfsa_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 48;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;

  // Frame states
  localparam logic [1:0] FRAME_FREE     = 2'd0;
  localparam logic [1:0] FRAME_LOCKED   = 2'd1;
  localparam logic [1:0] FRAME_RESERVED = 2'd2;

  // Input kinds
  localparam logic [2:0] KIND_MAP       = 3'd0;
  localparam logic [2:0] KIND_LOCK      = 3'd1;
  localparam logic [2:0] KIND_FREE      = 3'd2;
  localparam logic [2:0] KIND_RESERVE   = 3'd3;
  localparam logic [2:0] KIND_UNRESERVE = 3'd4;
  localparam logic [2:0] KIND_REQUEST   = 3'd5;
  localparam logic [2:0] KIND_LOOKUP    = 3'd6;

  // Result status codes
  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;
  localparam logic [1:0] STATUS_NONE     = 2'd3;

  typedef struct packed {
    logic [2:0]        kind;
    logic [IDX_W-1:0]  frame_index;
    logic [ADDR_W-1:0] byte_address;
    logic              usable;
  } pfsa_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  found_index;
    logic [ADDR_W-1:0] frame_address;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  locked_count_out;
    logic [CNT_W-1:0]  reserved_count_out;
  } pfsa_out_t;

  // Write request into the frame tables
  typedef struct packed {
    logic              st_we;
    logic              pg_we;
    logic [IDX_W-1:0]  addr;
    logic [1:0]        st_data;
    logic [PAGE_W-1:0] pg_data;
  } pfsa_wr_t;

endpackage

// File: hdl/pfsa_store.sv
// Frame state and page number memories with the post-reset clearing sweep.
module pfsa_store
  import pfsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  pfsa_wr_t          wr,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [1:0]        st_rdata,
  output logic [PAGE_W-1:0] pg_rdata,
  output logic              clearing
);

  logic [1:0]        st_mem [MAX_FRAMES];
  logic [PAGE_W-1:0] pg_mem [MAX_FRAMES];
  logic [IDX_W-1:0]  clr_idx;

  // Advance the clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == IDX_W'(MAX_FRAMES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // State memory: sweep writes take the port while clearing
  always_ff @(posedge clk) begin
    if (clearing) begin
      st_mem[clr_idx] <= FRAME_FREE;
    end else if (wr.st_we) begin
      st_mem[wr.addr] <= wr.st_data;
    end
    st_rdata <= st_mem[rd_addr];
  end

  // Page number memory
  always_ff @(posedge clk) begin
    if (wr.pg_we) begin
      pg_mem[wr.addr] <= wr.pg_data;
    end
    pg_rdata <= pg_mem[rd_addr];
  end

endmodule

// File: hdl/page_frame_state_allocator.sv
// Top level: sequencer around the frame tables, one shared entry compare for scans.
// Map, lock, free, reserve, unreserve go through READ, CHECK and EMIT; out of range goes to EMIT.
// Request and lookup scan one frame per cycle from frame 0 up to the first hit, or through the
//   saturated frame_count when none is found; an empty table or unknown kind goes to EMIT.
// One transaction at a time; the next is accepted once the result sits in the output register.
// Reset (synchronous) clears totals and frame_count, then a sweep frees every frame.
module page_frame_state_allocator
  import pfsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pfsa_in_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output pfsa_out_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_CHECK = 6'b001000,
    S_SCAN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  frame_count;
  logic [CNT_W-1:0]  locked_total;
  logic [CNT_W-1:0]  reserved_total;
  logic [2:0]        kind_q;
  logic [IDX_W-1:0]  idx_q;
  logic [ADDR_W-1:0] addr_q;
  logic              usable_q;
  logic [CNT_W-1:0]  scan_idx;
  logic              cmp_valid;
  logic [IDX_W-1:0]  cmp_idx;
  logic [1:0]        res_status;
  logic [IDX_W-1:0]  res_found;
  logic [ADDR_W-1:0] res_addr;

  logic [CNT_W-1:0]  eff_n;
  logic [PAGE_W-1:0] page_q;
  pfsa_wr_t          wr;
  logic [IDX_W-1:0]  rd_addr;
  logic [1:0]        st_rdata;
  logic [PAGE_W-1:0] pg_rdata;
  logic              clearing;
  logic              lk_up, lk_dn, rs_up, rs_dn;
  logic [1:0]        chk_status;
  logic              scan_hit;
  logic              scan_last;
  logic [CNT_W:0]    used;
  logic [CNT_W-1:0]  free_now;

  pfsa_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .st_rdata (st_rdata),
    .pg_rdata (pg_rdata),
    .clearing (clearing)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Saturate the configured count to the table depth
  assign eff_n  = (frame_count > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : frame_count;
  assign page_q = addr_q[ADDR_W-1:PAGE_SHIFT];

  assign rd_addr = (state == S_SCAN) ? scan_idx[IDX_W-1:0] : idx_q;

  // Shared compare: free state for request, page match for lookup
  assign scan_hit  = cmp_valid && ((kind_q == KIND_REQUEST) ? (st_rdata == FRAME_FREE)
                                                             : (pg_rdata == page_q));
  assign scan_last = ({1'b0, cmp_idx} + 1'b1) == eff_n;

  // Free count from the totals, floored at zero
  assign used     = {1'b0, locked_total} + {1'b0, reserved_total};
  assign free_now = ({1'b0, eff_n} > used) ? CNT_W'({1'b0, eff_n} - used) : '0;

  // Decide table writes and total updates
  always_comb begin
    wr         = '0;
    wr.addr    = idx_q;
    wr.st_data = FRAME_FREE;
    wr.pg_data = page_q;
    lk_up      = 1'b0;
    lk_dn      = 1'b0;
    rs_up      = 1'b0;
    rs_dn      = 1'b0;
    chk_status = STATUS_MISMATCH;
    if (state == S_CHECK) begin
      unique case (kind_q)
        KIND_MAP: begin
          wr.pg_we   = 1'b1;
          chk_status = STATUS_DONE;
          if (!usable_q) begin
            if (st_rdata == FRAME_FREE) begin
              wr.st_we   = 1'b1;
              wr.st_data = FRAME_RESERVED;
              rs_up      = 1'b1;
            end else begin
              chk_status = STATUS_MISMATCH;
            end
          end
        end
        KIND_LOCK: begin
          if (st_rdata == FRAME_FREE) begin
            wr.st_we   = 1'b1;
            wr.st_data = FRAME_LOCKED;
            lk_up      = 1'b1;
            chk_status = STATUS_DONE;
          end
        end
        KIND_FREE: begin
          if (st_rdata == FRAME_LOCKED) begin
            wr.st_we   = 1'b1;
            lk_dn      = 1'b1;
            chk_status = STATUS_DONE;
          end
        end
        KIND_RESERVE: begin
          if (st_rdata == FRAME_FREE) begin
            wr.st_we   = 1'b1;
            wr.st_data = FRAME_RESERVED;
            rs_up      = 1'b1;
            chk_status = STATUS_DONE;
          end
        end
        KIND_UNRESERVE: begin
          if (st_rdata == FRAME_RESERVED) begin
            wr.st_we   = 1'b1;
            rs_dn      = 1'b1;
            chk_status = STATUS_DONE;
          end
        end
        default: begin
          chk_status = STATUS_MISMATCH;
        end
      endcase
    end else if ((state == S_SCAN) && scan_hit && (kind_q == KIND_REQUEST)) begin
      wr.addr    = cmp_idx;
      wr.st_we   = 1'b1;
      wr.st_data = FRAME_LOCKED;
      lk_up      = 1'b1;
    end
  end

  // Sequencer, totals and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      frame_count    <= '0;
      locked_total   <= '0;
      reserved_total <= '0;
      cmp_valid      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        frame_count <= cfg_data;
      end

      if (lk_up) begin
        locked_total <= locked_total + 1'b1;
      end else if (lk_dn) begin
        locked_total <= locked_total - 1'b1;
      end
      if (rs_up) begin
        reserved_total <= reserved_total + 1'b1;
      end else if (rs_dn) begin
        reserved_total <= reserved_total - 1'b1;
      end

      // Drop the result once taken, unless the next one loads this cycle
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (!clearing) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            kind_q    <= in_item.kind;
            idx_q     <= in_item.frame_index;
            addr_q    <= in_item.byte_address;
            usable_q  <= in_item.usable;
            res_found <= '0;
            res_addr  <= '0;
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
            if ((in_item.kind <= KIND_UNRESERVE) &&
                ({1'b0, in_item.frame_index} >= eff_n)) begin
              res_status <= STATUS_RANGE;
              state      <= S_EMIT;
            end else if ((in_item.kind == KIND_REQUEST) ||
                         (in_item.kind == KIND_LOOKUP)) begin
              if (eff_n == '0) begin
                res_status <= STATUS_NONE;
                state      <= S_EMIT;
              end else begin
                state <= S_SCAN;
              end
            end else if (in_item.kind > KIND_LOOKUP) begin
              res_status <= STATUS_MISMATCH;
              state      <= S_EMIT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          res_status <= chk_status;
          state      <= S_EMIT;
        end
        S_SCAN: begin
          // Issue the next read while the previous entry is compared
          cmp_valid <= (scan_idx < eff_n);
          cmp_idx   <= scan_idx[IDX_W-1:0];
          if (scan_idx < eff_n) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (scan_hit) begin
            res_status <= STATUS_DONE;
            res_found  <= cmp_idx;
            res_addr   <= {pg_rdata, {PAGE_SHIFT{1'b0}}};
            state      <= S_EMIT;
          end else if (cmp_valid && scan_last) begin
            res_status <= STATUS_NONE;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_item.status             <= res_status;
            out_item.found_index        <= res_found;
            out_item.frame_address      <= res_addr;
            out_item.free_count         <= free_now;
            out_item.locked_count_out   <= locked_total;
            out_item.reserved_count_out <= reserved_total;
            out_valid                   <= 1'b1;
            state                       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
